@@ design/track_collision_check_unit_assert.svh @@
// Assertion macros shared by the track collision check RTL
`ifndef TRACK_COLLISION_CHECK_UNIT_ASSERT_SVH
`define TRACK_COLLISION_CHECK_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TCC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tcc_pkg.sv @@
// Package for the track collision check: types, constants and phase helper
package tcc_pkg;
   localparam int MaxPoints     = 64;
   localparam int CoordFracBits = 8;
   localparam int HeadingBits   = 16;

   localparam logic [14:0] Q14One = 15'd16384;
   localparam logic [14:0] SinA   = 15'd25736;
   localparam logic [13:0] SinB   = 14'd10512;
   localparam logic [10:0] SinC   = 11'd1160;

   localparam logic [2:0] CsrMethod     = 3'd0;
   localparam logic [2:0] CsrHostWidth  = 3'd1;
   localparam logic [2:0] CsrHostLength = 3'd2;
   localparam logic [2:0] CsrRemWidth   = 3'd3;
   localparam logic [2:0] CsrRemLength  = 3'd4;
   localparam logic [2:0] CsrGapX       = 3'd5;
   localparam logic [2:0] CsrGapY       = 3'd6;

   localparam logic [1:0] RiskNone    = 2'd0;
   localparam logic [1:0] RiskHit     = 2'd1;
   localparam logic [1:0] RiskUnknown = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic        test;       // index is in range, run the test
      logic        last;
      logic        bad_len;
      logic [5:0]  idx;
      logic        mode;
      logic [24:0] adx;
      logic [24:0] ady;
      logic [14:0] hs;
      logic [14:0] hc;
      logic [14:0] rs;
      logic [14:0] rc;
   } item_type;

   typedef struct packed {
      logic        method;
      logic [12:0] host_width;
      logic [12:0] host_length;
      logic [12:0] rem_width;
      logic [12:0] rem_length;
      logic [7:0]  gap_x;
      logic [7:0]  gap_y;
   } cfg_type;

   function automatic logic [15:0] phase16(input logic [HeadingBits-1:0] h);
      logic [31:0] w;
      begin
         w = 32'(h) << 16;
         phase16 = w[HeadingBits +: 16];
      end
   endfunction
endpackage

@@ design/tcc_sincos.sv @@
// Pipelined quarter-wave |sin| and |cos| of one heading, five register stages
module tcc_sincos (
   input  logic        clock,
   input  logic        adv,
   input  logic [15:0] phase,
   output logic [14:0] abs_sin,
   output logic [14:0] abs_cos
);
   // two evaluations: a = qsin(t), b = qsin(1-t)
   logic [14:0] ua_ff, ub_ff, ua2_ff, ub2_ff, ua3_ff, ub3_ff, ua4_ff, ub4_ff;
   logic        q_ff, q2_ff, q3_ff, q4_ff, q5_ff;
   logic [14:0] xa_ff, xb_ff, xa2_ff, xb2_ff;
   logic [13:0] t1a_ff, t1b_ff;
   logic [14:0] t2a_ff, t2b_ff;
   logic [14:0] sa_ff, sb_ff;
   logic [29:0] pa, pb;
   logic [24:0] ca, cb;
   logic [28:0] da, db;
   logic [29:0] ea, eb;

   function automatic logic [24:0] SinCmul(input logic [14:0] x);
      SinCmul = 25'(x) * 25'(tcc_pkg::SinC);
   endfunction

   function automatic logic [14:0] clampq(input logic [29:0] p);
      clampq = (p[29:14] > 16'(tcc_pkg::Q14One)) ? tcc_pkg::Q14One : p[28:14];
   endfunction

   always_comb begin
      pa = ua_ff * ua_ff;
      pb = ub_ff * ub_ff;
      ca = SinCmul(xa_ff);
      cb = SinCmul(xb_ff);
      da = xa2_ff * t1a_ff;
      db = xb2_ff * t1b_ff;
      ea = ua4_ff * t2a_ff;
      eb = ub4_ff * t2b_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ua_ff  <= {1'b0, phase[13:0]};
         ub_ff  <= tcc_pkg::Q14One - {1'b0, phase[13:0]};
         q_ff   <= phase[14];
         xa_ff  <= pa[28:14];
         xb_ff  <= pb[28:14];
         ua2_ff <= ua_ff;
         ub2_ff <= ub_ff;
         q2_ff  <= q_ff;
         t1a_ff <= tcc_pkg::SinB - ca[24:14];
         t1b_ff <= tcc_pkg::SinB - cb[24:14];
         xa2_ff <= xa_ff;
         xb2_ff <= xb_ff;
         ua3_ff <= ua2_ff;
         ub3_ff <= ub2_ff;
         q3_ff  <= q2_ff;
         t2a_ff <= tcc_pkg::SinA - da[28:14];
         t2b_ff <= tcc_pkg::SinA - db[28:14];
         ua4_ff <= ua3_ff;
         ub4_ff <= ub3_ff;
         q4_ff  <= q3_ff;
         sa_ff  <= clampq(ea);
         sb_ff  <= clampq(eb);
         q5_ff  <= q4_ff;
      end
   end

   // keep stage-2..5 operand registers aligned
   assign abs_sin = q5_ff ? sb_ff : sa_ff;
   assign abs_cos = q5_ff ? sa_ff : sb_ff;
endmodule

@@ design/tcc_front.sv @@
// Front end: accept point pairs, count indexes, compute distances and trig
module tcc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [6:0]          host_len,
   input  logic [6:0]          rem_len,
   input  logic signed [23:0]  host_x,
   input  logic signed [23:0]  host_y,
   input  logic [15:0]         host_heading,
   input  logic signed [23:0]  rem_x,
   input  logic signed [23:0]  rem_y,
   input  logic [15:0]         rem_heading,
   input  logic                last,
   input  tcc_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output tcc_pkg::item_type   out_item
);
   localparam int Depth = 5;
   logic [Depth-1:0]  vld_ff;
   tcc_pkg::item_type it_ff [Depth];
   logic [6:0]        cnt_ff;
   logic              adv;
   logic signed [24:0] dx, dy;
   tcc_pkg::item_type  it_in;
   logic [14:0] out_item_hs, out_item_hc, out_item_rs, out_item_rc;

   assign adv       = !vld_ff[Depth-1] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[Depth-1];

   // trig leaves the sin/cos pipeline in step with the last item stage
   always_comb begin
      out_item    = it_ff[Depth-1];
      out_item.hs = out_item_hs;
      out_item.hc = out_item_hc;
      out_item.rs = out_item_rs;
      out_item.rc = out_item_rc;
   end

   always_comb begin
      dx = 25'(host_x) - 25'(rem_x);
      dy = 25'(host_y) - 25'(rem_y);
      it_in = '0;
      it_in.test = (cnt_ff < host_len) && (cnt_ff < 7'(tcc_pkg::MaxPoints));
      it_in.last = last;
      it_in.bad_len = (host_len == 7'd0) || (rem_len == 7'd0) || (host_len != rem_len)
                      || (host_len > 7'(tcc_pkg::MaxPoints));
      it_in.idx  = cnt_ff[5:0];
      it_in.mode = cfg.method;
      it_in.adx  = dx[24] ? 25'(-dx) : 25'(dx);
      it_in.ady  = dy[24] ? 25'(-dy) : 25'(dy);
   end

   tcc_sincos u_hsc (.clock(clock), .adv(adv),
      .phase(tcc_pkg::phase16(host_heading)), .abs_sin(out_item_hs), .abs_cos(out_item_hc));
   tcc_sincos u_rsc (.clock(clock), .adv(adv),
      .phase(tcc_pkg::phase16(rem_heading)), .abs_sin(out_item_rs), .abs_cos(out_item_rc));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], in_valid};
         if (in_valid) begin
            cnt_ff <= last ? 7'd0 : ((cnt_ff == 7'd127) ? cnt_ff : cnt_ff + 7'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff[0] <= it_in;
         for (int i = 1; i < Depth; i++) begin
            it_ff[i] <= it_ff[i-1];
         end
      end
   end
endmodule

@@ design/tcc_back.sv @@
// Back end: extents, overlap test, sticky hit and verdict register
module tcc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  tcc_pkg::item_type in_item,
   input  tcc_pkg::cfg_type  cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_risk,
   output logic [5:0]        rsp_hit
);
   `include "track_collision_check_unit_assert.svh"

   // stage 1: products; stage 2: sums and compare; stage 3: verdict
   logic              v1_ff, v2_ff, vo_ff;
   tcc_pkg::item_type i1_ff;
   logic [27:0]       hls_ff, hwc_ff, hlc_ff, hws_ff, rls_ff, rwc_ff, rlc_ff, rws_ff;
   logic              risky;
   logic              t2_ff, l2_ff, b2_ff, r2_ff;
   logic [5:0]        x2_ff;
   logic              seen_ff;
   logic [5:0]        first_ff;
   logic [1:0]        risk_ff;
   logic [5:0]        hit_ff;
   logic              adv;
   logic [39:0]       ddx, ddy;
   logic [29:0]       ex, ey;
   logic              box, pt, hit_now;

   assign adv      = !vo_ff || rsp_ready;
   assign in_ready = adv;

   always_comb begin
      ddx = 40'(i1_ff.adx) << 15;
      ddy = 40'(i1_ff.ady) << 15;
      ex  = 30'(hls_ff) + 30'(hwc_ff) + 30'(rls_ff) + 30'(rwc_ff);
      ey  = 30'(hlc_ff) + 30'(hws_ff) + 30'(rlc_ff) + 30'(rws_ff);
      box = (ddx <= 40'(ex)) && (ddy <= 40'(ey));
      pt  = (i1_ff.adx[24:8] < 17'(cfg.gap_x)) && (i1_ff.ady[24:8] < 17'(cfg.gap_y));
      risky = i1_ff.mode ? box : pt;
      hit_now = t2_ff && r2_ff && !seen_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i1_ff  <= in_item;
         hls_ff <= cfg.host_length * in_item.hs;
         hwc_ff <= cfg.host_width * in_item.hc;
         hlc_ff <= cfg.host_length * in_item.hc;
         hws_ff <= cfg.host_width * in_item.hs;
         rls_ff <= cfg.rem_length * in_item.rs;
         rwc_ff <= cfg.rem_width * in_item.rc;
         rlc_ff <= cfg.rem_length * in_item.rc;
         rws_ff <= cfg.rem_width * in_item.rs;
         t2_ff  <= i1_ff.test;
         l2_ff  <= i1_ff.last;
         b2_ff  <= i1_ff.bad_len;
         x2_ff  <= i1_ff.idx;
         r2_ff  <= risky;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         vo_ff    <= 1'b0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         risk_ff  <= tcc_pkg::RiskNone;
         hit_ff   <= '0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         vo_ff <= v2_ff && l2_ff;
         if (v2_ff) begin
            if (l2_ff) begin
               seen_ff  <= 1'b0;
               first_ff <= '0;
               if (b2_ff) begin
                  risk_ff <= tcc_pkg::RiskUnknown;
                  hit_ff  <= '0;
               end else if (seen_ff || hit_now) begin
                  risk_ff <= tcc_pkg::RiskHit;
                  hit_ff  <= seen_ff ? first_ff : x2_ff;
               end else begin
                  risk_ff <= tcc_pkg::RiskNone;
                  hit_ff  <= '0;
               end
            end else if (hit_now) begin
               seen_ff  <= 1'b1;
               first_ff <= x2_ff;
            end
         end
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_risk  = risk_ff;
   assign rsp_hit   = hit_ff;

   `TCC_ASSERT_IMPL(a_risk_code, clock, reset, rsp_valid,
      rsp_risk != 2'd3, "risk code out of range")
   `TCC_ASSERT_IMPL(a_hit_zero, clock, reset, rsp_valid && rsp_risk != tcc_pkg::RiskHit,
      rsp_hit == 6'd0, "hit index set without hit")
   `TCC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_risk) && $stable(rsp_hit), "verdict changed under stall")
endmodule

@@ design/track_collision_check_unit.sv @@
// Track collision check top level: CSRs, front end, queue stage and back end
// Takes one point pair per cycle, back to back, while req_tready is high; the
// verdict for the pair flagged last passes the five-stage sin/cos pipeline, the
// queue stage and the back end's product, compare and verdict stages.
module track_collision_check_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: host_track_len[6:0], remote_track_len[13:7], host_x[37:14],
   // host_y[61:38], host_heading[77:62], remote_x[101:78], remote_y[125:102],
   // remote_heading[141:126], zero pad
   input  logic [143:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: risk[1:0], hit_index[7:2]
   output logic [7:0]   rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [12:0]  csr_wdata
);
   tcc_pkg::cfg_type  cfg_ff;
   tcc_pkg::item_type f_item, q_item_ff;
   logic              f_valid, q_ready, q_valid_ff, b_ready;
   logic [1:0]        risk;
   logic [5:0]        hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method      <= 1'b1;
         cfg_ff.host_width  <= 13'd512;
         cfg_ff.host_length <= 13'd1152;
         cfg_ff.rem_width   <= 13'd512;
         cfg_ff.rem_length  <= 13'd1152;
         cfg_ff.gap_x       <= 8'd2;
         cfg_ff.gap_y       <= 8'd5;
      end else if (csr_we) begin
         unique case (csr_index)
            tcc_pkg::CsrMethod:     cfg_ff.method      <= csr_wdata[0];
            tcc_pkg::CsrHostWidth:  cfg_ff.host_width  <= csr_wdata;
            tcc_pkg::CsrHostLength: cfg_ff.host_length <= csr_wdata;
            tcc_pkg::CsrRemWidth:   cfg_ff.rem_width   <= csr_wdata;
            tcc_pkg::CsrRemLength:  cfg_ff.rem_length  <= csr_wdata;
            tcc_pkg::CsrGapX:       cfg_ff.gap_x       <= csr_wdata[7:0];
            tcc_pkg::CsrGapY:       cfg_ff.gap_y       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   tcc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .host_len(req_tdata[6:0]), .rem_len(req_tdata[13:7]),
      .host_x(req_tdata[37:14]), .host_y(req_tdata[61:38]),
      .host_heading(req_tdata[77:62]),
      .rem_x(req_tdata[101:78]), .rem_y(req_tdata[125:102]),
      .rem_heading(req_tdata[141:126]),
      .last(req_tlast), .cfg(cfg_ff),
      .out_valid(f_valid), .out_ready(q_ready), .out_item(f_item)
   );

   // one-entry queue between front and back
   assign q_ready = !q_valid_ff || b_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (q_ready) begin
         q_valid_ff <= f_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (q_ready) begin
         q_item_ff <= f_item;
      end
   end

   tcc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid_ff), .in_ready(b_ready), .in_item(q_item_ff),
      .cfg(cfg_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_risk(risk), .rsp_hit(hit)
   );

   assign rsp_tdata = {hit, risk};
endmodule
